/* hw/rtl/dmw_pkg.sv */
// Shared widths, constants and result type for the daily min/max estimator.
package dmw_pkg;

  localparam int TEMP_W  = 14;
  localparam int RH_W    = 14;
  localparam int WIND_W  = 15;
  localparam int LWIND_W = 12;
  localparam int HWIND_W = 15;

  // Q24 fraction x/(x+237.3) as a signed word
  localparam int F_W     = 25;
  localparam int DIV_DW  = 16;
  localparam int FRAC_QW = 24;
  localparam int LONG_QW = 48;
  localparam int K_W     = 8;

  localparam int EXP_DEPTH_DEF = 256;

  localparam logic [20:0] EXPO_K    = 21'd1632852;
  localparam logic [16:0] TC_OFF    = 17'd23730;
  localparam logic [16:0] TK_OFF    = 17'd27317;
  localparam logic [13:0] RH_CAP    = 14'd10000;
  localparam logic [19:0] RECIP_100 = 20'd671089;
  localparam int          RECIP_SH  = 26;
  localparam bit   [63:0] LN2_Q30   = 64'd744261118;
  localparam bit   [63:0] Q30_ONE   = 64'd1073741824;

  // Frac divider plus sign fix-up, then the humidity path
  localparam int FRAC_LAT = FRAC_QW + 2;
  localparam int HUM_LAT  = LONG_QW + 9;

  typedef struct packed {
    logic signed [TEMP_W-1:0]  low_temp;
    logic signed [TEMP_W-1:0]  high_temp;
    logic        [RH_W-1:0]    low_humidity;
    logic        [RH_W-1:0]    high_humidity;
    logic        [LWIND_W-1:0] low_wind;
    logic        [HWIND_W-1:0] high_wind;
  } res_t;

endpackage

/* hw/rtl/dmw_if.sv */
// Request and result channel interfaces.
interface dmw_in_if;
  import dmw_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] air_temp;
  logic        [RH_W-1:0]   rel_humidity;
  logic        [WIND_W-1:0] wind_speed;
  modport source (output valid, air_temp, rel_humidity, wind_speed, input ready);
  modport sink   (input valid, air_temp, rel_humidity, wind_speed, output ready);
endinterface

interface dmw_out_if;
  import dmw_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [TEMP_W-1:0]  low_temp;
  logic signed [TEMP_W-1:0]  high_temp;
  logic        [RH_W-1:0]    low_humidity;
  logic        [RH_W-1:0]    high_humidity;
  logic        [LWIND_W-1:0] low_wind;
  logic        [HWIND_W-1:0] high_wind;
  modport source (output valid, low_temp, high_temp, low_humidity, high_humidity,
                  low_wind, high_wind, input ready);
  modport sink   (input valid, low_temp, high_temp, low_humidity, high_humidity,
                  low_wind, high_wind, output ready);
endinterface

/* hw/rtl/dmw_delay.sv */
// Enabled shift-register delay line for sideband data.
module dmw_delay #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);
  logic [W-1:0] sr_q [D];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < D; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[D-1];
endmodule

/* hw/rtl/dmw_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with a tag sideband.
module dmw_div #(
  parameter int QW = 24,
  parameter int TW = 1
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [dmw_pkg::DIV_DW+QW-1:0]  num_i,
  input  logic [dmw_pkg::DIV_DW-1:0]     dv_i,
  input  logic [TW-1:0]                  tag_i,
  output logic [QW-1:0]                  quo_o,
  output logic [dmw_pkg::DIV_DW-1:0]     rem_o,
  output logic [TW-1:0]                  tag_o
);
  import dmw_pkg::*;

  logic [DIV_DW-1:0] rem_q [QW+1];
  logic [DIV_DW-1:0] dv_q  [QW+1];
  logic [QW-1:0]     lo_q  [QW+1];
  logic [QW-1:0]     quo_q [QW+1];
  logic [TW-1:0]     tag_q [QW+1];

  // Upper numerator bits are below the divisor by construction
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i[QW +: DIV_DW];
      lo_q[0]  <= num_i[QW-1:0];
      quo_q[0] <= '0;
      dv_q[0]  <= dv_i;
      tag_q[0] <= tag_i;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_step
    logic [DIV_DW:0] trial;
    logic            fits;

    assign trial = {rem_q[j-1], lo_q[j-1][QW-1]};
    assign fits  = trial >= {1'b0, dv_q[j-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= fits ? DIV_DW'(trial - {1'b0, dv_q[j-1]}) : DIV_DW'(trial);
        lo_q[j]  <= {lo_q[j-1][QW-2:0], 1'b0};
        quo_q[j] <= {quo_q[j-1][QW-2:0], fits};
        dv_q[j]  <= dv_q[j-1];
        tag_q[j] <= tag_q[j-1];
      end
    end
  end

  assign quo_o = quo_q[QW];
  assign rem_o = rem_q[QW];
  assign tag_o = tag_q[QW];
endmodule

/* hw/rtl/dmw_hum.sv */
// Humidity extreme path: exponent, 2^x table interpolation, scale and divide, round.
module dmw_hum #(
  parameter int EXP_TABLE_DEPTH = dmw_pkg::EXP_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [dmw_pkg::F_W-1:0]     f_t_i,
  input  logic signed [dmw_pkg::F_W-1:0]     f_tp_i,
  input  logic signed [dmw_pkg::TEMP_W-1:0]  t_i,
  input  logic signed [dmw_pkg::TEMP_W-1:0]  tp_i,
  input  logic        [dmw_pkg::RH_W-1:0]    rh_i,
  output logic        [dmw_pkg::RH_W-1:0]    rh_o
);
  import dmw_pkg::*;

  localparam int IW = $clog2(EXP_TABLE_DEPTH);
  localparam int TW = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int PW = 24 + IW;
  localparam logic [PW-1:0] NCONST = PW'(EXP_TABLE_DEPTH);

  // 2^(i/N) in Q2.30, truncated Taylor series evaluated at elaboration
  logic [31:0] tab [EXP_TABLE_DEPTH+1];

  for (genvar gi = 0; gi <= EXP_TABLE_DEPTH; gi++) begin : g_tab
    localparam bit [63:0] Z   = 64'(gi) * LN2_Q30 / 64'(EXP_TABLE_DEPTH);
    localparam bit [63:0] T01 = ((Q30_ONE * Z) >> 30) / 1;
    localparam bit [63:0] T02 = ((T01 * Z) >> 30) / 2;
    localparam bit [63:0] T03 = ((T02 * Z) >> 30) / 3;
    localparam bit [63:0] T04 = ((T03 * Z) >> 30) / 4;
    localparam bit [63:0] T05 = ((T04 * Z) >> 30) / 5;
    localparam bit [63:0] T06 = ((T05 * Z) >> 30) / 6;
    localparam bit [63:0] T07 = ((T06 * Z) >> 30) / 7;
    localparam bit [63:0] T08 = ((T07 * Z) >> 30) / 8;
    localparam bit [63:0] T09 = ((T08 * Z) >> 30) / 9;
    localparam bit [63:0] T10 = ((T09 * Z) >> 30) / 10;
    localparam bit [63:0] T11 = ((T10 * Z) >> 30) / 11;
    localparam bit [63:0] T12 = ((T11 * Z) >> 30) / 12;
    localparam bit [63:0] T13 = ((T12 * Z) >> 30) / 13;
    localparam bit [63:0] T14 = ((T13 * Z) >> 30) / 14;
    localparam bit [63:0] T15 = ((T14 * Z) >> 30) / 15;
    localparam bit [63:0] T16 = ((T15 * Z) >> 30) / 16;
    localparam bit [63:0] T17 = ((T16 * Z) >> 30) / 17;
    localparam bit [63:0] T18 = ((T17 * Z) >> 30) / 18;
    localparam bit [63:0] T19 = ((T18 * Z) >> 30) / 19;
    localparam bit [63:0] T20 = ((T19 * Z) >> 30) / 20;
    localparam bit [63:0] SUM = Q30_ONE + T01 + T02 + T03 + T04 + T05 + T06 + T07
                              + T08 + T09 + T10 + T11 + T12 + T13 + T14 + T15
                              + T16 + T17 + T18 + T19 + T20;
    assign tab[gi] = SUM[31:0];
  end

  // Stage 1: exponent product
  logic signed [25:0] d;
  logic signed [47:0] d48, k48, prod1_d;
  logic signed [47:0] prod1_q;
  logic [RH_W-1:0]    rh1_q, rh2_q, rh3_q, rh4_q;
  logic signed [TEMP_W-1:0] t1_q, t2_q, t3_q, t4_q, t5_q, t6_q;
  logic signed [TEMP_W-1:0] tp1_q, tp2_q, tp3_q, tp4_q, tp5_q;

  assign d       = {f_t_i[F_W-1], f_t_i} - {f_tp_i[F_W-1], f_tp_i};
  assign d48     = {{22{d[25]}}, d};
  assign k48     = $signed({27'b0, EXPO_K});
  assign prod1_d = d48 * k48;

  // Stage 2: split exponent, scale fraction by table depth
  logic signed [47:0] ysh;
  logic [31:0]        y;
  logic [PW-1:0]      p2_d, p2_q;
  logic [K_W-1:0]     k2_q, k3_q, k4_q, k5_q, k6_q;

  assign ysh  = prod1_q >>> 16;
  assign y    = ysh[31:0];
  assign p2_d = PW'(y[23:0]) * NCONST;

  // Stage 3: table lookup
  logic [IW-1:0] idx;
  logic [TW-1:0] idx0, idx1;
  logic [31:0]   e0_3_q, e1_3_q, e0_4_q;
  logic [23:0]   r3_q;

  assign idx  = p2_q[24 +: IW];
  assign idx0 = TW'(idx);
  assign idx1 = TW'(idx) + TW'(1);

  // Stage 4: interpolation product
  logic [55:0] dr4_d, dr4_q;
  assign dr4_d = 56'(e1_3_q - e0_3_q) * 56'(r3_q);

  // Stage 5: mantissa times humidity
  logic [31:0] m;
  logic [45:0] rhm5_d, rhm5_q;
  assign m      = e0_4_q + dr4_q[55:24];
  assign rhm5_d = 46'(rh4_q) * 46'(m);

  // Stage 6: times Kelvin of the target temperature
  logic [16:0] tkp_s, tk_s;
  logic [61:0] num6_d, num6_q;
  assign tkp_s  = {{3{tp5_q[TEMP_W-1]}}, tp5_q} + TK_OFF;
  assign num6_d = 62'(rhm5_q) * 62'(tkp_s[15:0]);
  assign tk_s   = {{3{t6_q[TEMP_W-1]}}, t6_q} + TK_OFF;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod1_q <= prod1_d;
      rh1_q   <= rh_i;
      t1_q    <= t_i;
      tp1_q   <= tp_i;

      p2_q    <= p2_d;
      k2_q    <= y[31:24];
      rh2_q   <= rh1_q;
      t2_q    <= t1_q;
      tp2_q   <= tp1_q;

      e0_3_q  <= tab[idx0];
      e1_3_q  <= tab[idx1];
      r3_q    <= p2_q[23:0];
      k3_q    <= k2_q;
      rh3_q   <= rh2_q;
      t3_q    <= t2_q;
      tp3_q   <= tp2_q;

      dr4_q   <= dr4_d;
      e0_4_q  <= e0_3_q;
      k4_q    <= k3_q;
      rh4_q   <= rh3_q;
      t4_q    <= t3_q;
      tp4_q   <= tp3_q;

      rhm5_q  <= rhm5_d;
      k5_q    <= k4_q;
      t5_q    <= t4_q;
      tp5_q   <= tp4_q;

      num6_q  <= num6_d;
      k6_q    <= k5_q;
      t6_q    <= t5_q;
    end
  end

  // Divide by Kelvin of the noon temperature
  logic [LONG_QW-1:0] quo;
  logic [K_W-1:0]     k_div;

  dmw_div #(
    .QW (LONG_QW),
    .TW (K_W)
  ) u_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i ((DIV_DW+LONG_QW)'(num6_q)),
    .dv_i  (tk_s[15:0]),
    .tag_i (k6_q),
    .quo_o (quo),
    .rem_o (),
    .tag_o (k_div)
  );

  // Stage 7: rounding add for shift s = 30 - k
  logic signed [8:0] s;
  logic              s_low, s_high;
  logic [5:0]        s6;
  logic [63:0]       sum7_d, sum7_q;
  logic [5:0]        s7_q;
  logic              low7_q, high7_q, qnz7_q;

  assign s      = 9'sd30 - {k_div[K_W-1], k_div};
  assign s_low  = s <= 9'sd0;
  assign s_high = s >= 9'sd63;
  assign s6     = (s_low || s_high) ? 6'd1 : s[5:0];
  assign sum7_d = 64'(quo) + (64'd1 << (s6 - 6'd1));

  // Stage 8: shift and cap
  logic [63:0]     shifted;
  logic [RH_W-1:0] res8_d, res8_q;

  assign shifted = sum7_q >> s7_q;

  always_comb begin
    if (low7_q) begin
      res8_d = qnz7_q ? RH_CAP : '0;
    end else if (high7_q) begin
      res8_d = '0;
    end else if (shifted > 64'(RH_CAP)) begin
      res8_d = RH_CAP;
    end else begin
      res8_d = shifted[RH_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum7_q  <= sum7_d;
      s7_q    <= s6;
      low7_q  <= s_low;
      high7_q <= s_high;
      qnz7_q  <= quo != '0;
      res8_q  <= res8_d;
    end
  end

  assign rh_o = res8_q;
endmodule

/* hw/rtl/daily_minmax_weather_estimate.sv */
// Top level of the daily min/max weather estimator.
// One noon reading (temperature, humidity, wind) in, one set of estimated daily
// extremes out. The pipeline takes a request every cycle while the output buffer
// has a free slot and runs 86 register stages deep ahead of that buffer. Depth
// is set by the two bit-per-stage dividers: the divider for x/(x+237.3) and the
// divider by Kelvin temperature in each humidity path. A two-entry output buffer
// decouples the sides: requests keep flowing while a result waits, and the
// pipeline freezes only when both buffer slots are full. The 2^x table is built
// at elaboration and needs no load or clearing after reset.
module daily_minmax_weather_estimate #(
  parameter int EXP_TABLE_DEPTH = dmw_pkg::EXP_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  dmw_in_if.sink           in_i,
  dmw_out_if.source        out_o
);
  import dmw_pkg::*;

  localparam int VLD_LAT = FRAC_LAT + HUM_LAT;

  function automatic logic signed [TEMP_W-1:0] sat14(input logic signed [15:0] v);
    logic signed [TEMP_W-1:0] r;
    if (v > 16'sd8191) begin
      r = 14'sh1fff;
    end else if (v < -16'sd8192) begin
      r = 14'sh2000;
    end else begin
      r = v[TEMP_W-1:0];
    end
    return r;
  endfunction

  // Global advance: hold every stage while both output slots are full
  logic [1:0] cnt_q, cnt_d;
  logic       en;
  assign en        = cnt_q != 2'd2;
  assign in_i.ready = en;

  // Stage 0: capture the request
  logic                     vld0_q, vld1_q, vld2_q;
  logic signed [TEMP_W-1:0] t0_q, t1_q, t2_q;
  logic [RH_W-1:0]          rh0_q, rh1_q, rh2_q;
  logic [WIND_W-1:0]        w0_q;

  // Stage 1: range and wind products
  logic signed [20:0] n1;
  logic [18:0]        nn, wx;
  logic [38:0]        rp1_d, rp1_q, wp1_d, wp1_q;
  logic [17:0]        wh5;
  logic [HWIND_W-1:0] wh1_d, wh1_q, wh2_q;
  logic               narrow1_q;

  assign n1    = {{7{t0_q[TEMP_W-1]}}, t0_q} * 21'sd22
               - $signed(21'(rh0_q) * 21'd16) + 21'sd170000;
  assign nn    = 19'(n1 + 21'sd50);
  assign rp1_d = 39'(nn) * 39'(RECIP_100);
  assign wx    = 19'(w0_q) * 19'd15 + 19'd50;
  assign wp1_d = 39'(wx) * 39'(RECIP_100);
  assign wh5   = 18'(w0_q) * 18'd5 + 18'd2;
  assign wh1_d = (wh5[17:2] > 16'd32767) ? 15'h7fff : wh5[16:2];

  // Stage 2: daily extremes of temperature, low wind
  logic [12:0]              rng;
  logic signed [15:0]       text, hi_raw, lo_raw;
  logic signed [TEMP_W-1:0] hi2_q, lo2_q;
  logic [12:0]              wl_raw;
  logic [LWIND_W-1:0]       wl2_q;

  assign rng    = 13'(rp1_q >> RECIP_SH);
  assign text   = {{2{t1_q[TEMP_W-1]}}, t1_q};
  assign hi_raw = narrow1_q ? text + 16'sd100 : text + 16'sd200;
  assign lo_raw = narrow1_q ? text - 16'sd100 : hi_raw - $signed({3'b0, rng});
  assign wl_raw = 13'(wp1_q >> RECIP_SH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en) begin
      vld0_q <= in_i.valid;
      vld1_q <= vld0_q;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t0_q      <= in_i.air_temp;
      rh0_q     <= in_i.rel_humidity;
      w0_q      <= in_i.wind_speed;

      rp1_q     <= rp1_d;
      wp1_q     <= wp1_d;
      wh1_q     <= wh1_d;
      narrow1_q <= n1 <= 21'sd20000;
      t1_q      <= t0_q;
      rh1_q     <= rh0_q;

      hi2_q     <= sat14(hi_raw);
      lo2_q     <= sat14(lo_raw);
      wl2_q     <= (wl_raw > 13'd4095) ? 12'hfff : wl_raw[LWIND_W-1:0];
      wh2_q     <= wh1_q;
      t2_q      <= t1_q;
      rh2_q     <= rh1_q;
    end
  end

  // Fractions x/(x+237.3) for noon, high and low temperature, in Q24
  logic signed [TEMP_W-1:0] fx [3];
  logic signed [F_W-1:0]    f_q [3];

  assign fx[0] = t2_q;
  assign fx[1] = hi2_q;
  assign fx[2] = lo2_q;

  for (genvar gf = 0; gf < 3; gf++) begin : g_frac
    logic [16:0]        xe, mag;
    logic [16:0]        dvs;
    logic [FRAC_QW-1:0] quo;
    logic [DIV_DW-1:0]  rem;
    logic               neg;
    logic [F_W-1:0]     qe;

    assign xe  = {{3{fx[gf][TEMP_W-1]}}, fx[gf]};
    assign mag = fx[gf][TEMP_W-1] ? 17'd0 - xe : xe;
    assign dvs = xe + TC_OFF;

    dmw_div #(
      .QW (FRAC_QW),
      .TW (1)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i ({mag[15:0], {FRAC_QW{1'b0}}}),
      .dv_i  (dvs[15:0]),
      .tag_i (fx[gf][TEMP_W-1]),
      .quo_o (quo),
      .rem_o (rem),
      .tag_o (neg)
    );

    // Floor toward minus infinity for negative temperatures
    assign qe = F_W'(quo);

    always_ff @(posedge clk_i) begin
      if (en) begin
        f_q[gf] <= neg ? $signed(F_W'(0) - (qe + F_W'(rem != '0))) : $signed(qe);
      end
    end
  end

  // Align noon values with the fractions
  localparam int DA_W = 4 * TEMP_W + LWIND_W + HWIND_W;
  logic [DA_W-1:0]          da_in, da_out;
  logic signed [TEMP_W-1:0] t_a, hi_a, lo_a;
  logic [RH_W-1:0]          rh_a;
  logic [LWIND_W-1:0]       wl_a;
  logic [HWIND_W-1:0]       wh_a;

  assign da_in = {t2_q, rh2_q, hi2_q, lo2_q, wl2_q, wh2_q};
  assign {t_a, rh_a, hi_a, lo_a, wl_a, wh_a} = da_out;

  dmw_delay #(
    .W (DA_W),
    .D (FRAC_LAT)
  ) u_dly_a (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (da_in),
    .q_o   (da_out)
  );

  // Low humidity comes with the high temperature, high humidity with the low
  logic [RH_W-1:0] rh_low, rh_high;

  dmw_hum #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_hum_low (
    .clk_i  (clk_i),
    .en_i   (en),
    .f_t_i  (f_q[0]),
    .f_tp_i (f_q[1]),
    .t_i    (t_a),
    .tp_i   (hi_a),
    .rh_i   (rh_a),
    .rh_o   (rh_low)
  );

  dmw_hum #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_hum_high (
    .clk_i  (clk_i),
    .en_i   (en),
    .f_t_i  (f_q[0]),
    .f_tp_i (f_q[2]),
    .t_i    (t_a),
    .tp_i   (lo_a),
    .rh_i   (rh_a),
    .rh_o   (rh_high)
  );

  // Carry temperatures and winds past the humidity paths
  localparam int DB_W = 2 * TEMP_W + LWIND_W + HWIND_W;
  logic [DB_W-1:0]          db_out;
  logic signed [TEMP_W-1:0] hi_b, lo_b;
  logic [LWIND_W-1:0]       wl_b;
  logic [HWIND_W-1:0]       wh_b;

  assign {hi_b, lo_b, wl_b, wh_b} = db_out;

  dmw_delay #(
    .W (DB_W),
    .D (HUM_LAT)
  ) u_dly_b (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({hi_a, lo_a, wl_a, wh_a}),
    .q_o   (db_out)
  );

  // Valid bits travel alongside the data stages
  logic [VLD_LAT-1:0] vld_pipe_q;
  logic               vld_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_pipe_q <= '0;
    end else if (en) begin
      vld_pipe_q <= {vld_pipe_q[VLD_LAT-2:0], vld2_q};
    end
  end

  assign vld_end = vld_pipe_q[VLD_LAT-1];

  // Two-entry output buffer
  res_t slot_q [2];
  res_t res_new;
  logic wr_ptr_q, rd_ptr_q;
  logic push, pop;

  assign res_new.low_temp      = lo_b;
  assign res_new.high_temp     = hi_b;
  assign res_new.low_humidity  = rh_low;
  assign res_new.high_humidity = rh_high;
  assign res_new.low_wind      = wl_b;
  assign res_new.high_wind     = wh_b;

  assign push  = en && vld_end;
  assign pop   = out_o.valid && out_o.ready;
  assign cnt_d = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= res_new;
    end
  end

  assign out_o.valid         = cnt_q != 2'd0;
  assign out_o.low_temp      = slot_q[rd_ptr_q].low_temp;
  assign out_o.high_temp     = slot_q[rd_ptr_q].high_temp;
  assign out_o.low_humidity  = slot_q[rd_ptr_q].low_humidity;
  assign out_o.high_humidity = slot_q[rd_ptr_q].high_humidity;
  assign out_o.low_wind      = slot_q[rd_ptr_q].low_wind;
  assign out_o.high_wind     = slot_q[rd_ptr_q].high_wind;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_hold_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_pipe_q))
    else $error("pipeline advanced while output buffer full");

  a_temp_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.low_temp <= out_o.high_temp)
    else $error("low temperature above high temperature");

  a_rh_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.low_humidity <= RH_CAP && out_o.high_humidity <= RH_CAP))
    else $error("humidity result above cap");

  a_wind_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> 15'(out_o.low_wind) <= out_o.high_wind)
    else $error("low wind above high wind");
`endif
endmodule
